[src/rk4_pkg.sv]
package rk4_pkg;

  // fixed-point format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;
  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] FIX_TWO  = 32'h0200_0000;
  // reciprocal of six, exact for 32-bit magnitudes with a shift of 34
  localparam logic [31:0] RECIP_SIX = 32'haaaa_aaab;

  // configuration register indexes
  localparam logic [3:0] CFG_GAIN_RATE       = 4'd0;
  localparam logic [3:0] CFG_GAIN_DEFLECTION = 4'd1;
  localparam logic [3:0] CFG_ACTUATOR_GAIN   = 4'd2;
  localparam logic [3:0] CFG_TIME_CONSTANT   = 4'd3;
  localparam logic [3:0] CFG_STEP_SIZE       = 4'd4;
  localparam logic [3:0] CFG_INITIAL_ANGLE   = 4'd5;
  localparam logic [3:0] CFG_INITIAL_RATE    = 4'd6;
  localparam logic [3:0] CFG_INITIAL_DEFL    = 4'd7;

  typedef struct packed {
    logic signed [31:0] control;
    logic signed [31:0] disturbance;
    logic               restart;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] angle_out;
    logic signed [31:0] rate_out;
    logic signed [31:0] deflection_out;
    logic               saturated;
  } out_word_t;

  // shared unit operations
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_NEG,
    OP_HALF,
    OP_MUL,
    OP_DIV6,
    OP_DIVT
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_cmd_t;

  typedef struct packed {
    logic done;
    logic sat;
  } unit_status_t;

  // operand codes: below 32 a scratch entry, from 32 up a fixed register
  localparam logic [5:0] R_T0    = 6'd0;
  localparam logic [5:0] R_T1    = 6'd1;
  localparam logic [5:0] R_T2    = 6'd2;
  localparam logic [5:0] R_K1    = 6'd3;
  localparam logic [5:0] R_K2    = 6'd6;
  localparam logic [5:0] R_K3    = 6'd9;
  localparam logic [5:0] R_K4    = 6'd12;
  localparam logic [5:0] R_KU    = 6'd15;
  localparam logic [5:0] R_P     = 6'd16;
  localparam logic [5:0] R_S     = 6'd17;
  localparam logic [5:0] R_M     = 6'd18;
  localparam logic [5:0] R_N     = 6'd19;
  localparam logic [5:0] X_ANGLE = 6'd32;
  localparam logic [5:0] X_RATE  = 6'd33;
  localparam logic [5:0] X_DEFL  = 6'd34;
  localparam logic [5:0] X_C1    = 6'd35;
  localparam logic [5:0] X_C2    = 6'd36;
  localparam logic [5:0] X_KGAIN = 6'd37;
  localparam logic [5:0] X_DT    = 6'd38;
  localparam logic [5:0] X_TWO   = 6'd39;
  localparam logic [5:0] X_KSI   = 6'd40;
  localparam logic [5:0] X_CTRL  = 6'd41;

  typedef struct packed {
    op_t        op;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] d;
  } ucode_t;

  localparam logic [6:0] PC_LAST = 7'd76;

  // saturate a magnitude with a sign into a word: {sat, value}
  function automatic logic [32:0] sat_mag(input logic neg, input logic [55:0] q);
    logic [55:0] limit;
    logic [31:0] low;
    limit = neg ? 56'h0000_0080_0000_00 : 56'h0000_007f_ffff_ff;
    low   = q[31:0];
    if (q > limit) begin
      sat_mag = {1'b1, (neg ? WORD_MIN : WORD_MAX)};
    end else begin
      sat_mag = {1'b0, (neg ? (32'd0 - low) : low)};
    end
  endfunction

  // saturate a 33-bit signed sum into a word: {sat, value}
  function automatic logic [32:0] sat_sum(input logic [32:0] v);
    if (v[32] != v[31]) begin
      sat_sum = {1'b1, (v[32] ? WORD_MIN : WORD_MAX)};
    end else begin
      sat_sum = {1'b0, v[31:0]};
    end
  endfunction

  // step program: initial k*u, four derivative passes, stage updates, final sum
  function automatic ucode_t ucode(input logic [6:0] pc);
    unique case (pc)
      7'd0:  ucode = '{OP_MUL,  X_KGAIN,      X_CTRL,  R_KU};
      // first derivative from the state
      7'd1:  ucode = '{OP_NEG,  X_RATE,       X_RATE,  R_K1};
      7'd2:  ucode = '{OP_MUL,  X_C1,         X_RATE,  R_P};
      7'd3:  ucode = '{OP_MUL,  X_C2,         X_DEFL,  R_M};
      7'd4:  ucode = '{OP_SUB,  R_P,          R_M,     R_S};
      7'd5:  ucode = '{OP_SUB,  R_S,          X_KSI,   R_K1 + 6'd1};
      7'd6:  ucode = '{OP_SUB,  X_DEFL,       R_KU,    R_N};
      7'd7:  ucode = '{OP_DIVT, R_N,          R_N,     R_K1 + 6'd2};
      // half step with k1
      7'd8:  ucode = '{OP_MUL,  R_K1,         X_DT,    R_P};
      7'd9:  ucode = '{OP_HALF, R_P,          R_P,     R_P};
      7'd10: ucode = '{OP_ADD,  X_ANGLE,      R_P,     R_T0};
      7'd11: ucode = '{OP_MUL,  R_K1 + 6'd1,  X_DT,    R_P};
      7'd12: ucode = '{OP_HALF, R_P,          R_P,     R_P};
      7'd13: ucode = '{OP_ADD,  X_RATE,       R_P,     R_T1};
      7'd14: ucode = '{OP_MUL,  R_K1 + 6'd2,  X_DT,    R_P};
      7'd15: ucode = '{OP_HALF, R_P,          R_P,     R_P};
      7'd16: ucode = '{OP_ADD,  X_DEFL,       R_P,     R_T2};
      // second derivative
      7'd17: ucode = '{OP_NEG,  R_T1,         R_T1,    R_K2};
      7'd18: ucode = '{OP_MUL,  X_C1,         R_T1,    R_P};
      7'd19: ucode = '{OP_MUL,  X_C2,         R_T2,    R_M};
      7'd20: ucode = '{OP_SUB,  R_P,          R_M,     R_S};
      7'd21: ucode = '{OP_SUB,  R_S,          X_KSI,   R_K2 + 6'd1};
      7'd22: ucode = '{OP_SUB,  R_T2,         R_KU,    R_N};
      7'd23: ucode = '{OP_DIVT, R_N,          R_N,     R_K2 + 6'd2};
      // half step with k2
      7'd24: ucode = '{OP_MUL,  R_K2,         X_DT,    R_P};
      7'd25: ucode = '{OP_HALF, R_P,          R_P,     R_P};
      7'd26: ucode = '{OP_ADD,  X_ANGLE,      R_P,     R_T0};
      7'd27: ucode = '{OP_MUL,  R_K2 + 6'd1,  X_DT,    R_P};
      7'd28: ucode = '{OP_HALF, R_P,          R_P,     R_P};
      7'd29: ucode = '{OP_ADD,  X_RATE,       R_P,     R_T1};
      7'd30: ucode = '{OP_MUL,  R_K2 + 6'd2,  X_DT,    R_P};
      7'd31: ucode = '{OP_HALF, R_P,          R_P,     R_P};
      7'd32: ucode = '{OP_ADD,  X_DEFL,       R_P,     R_T2};
      // third derivative
      7'd33: ucode = '{OP_NEG,  R_T1,         R_T1,    R_K3};
      7'd34: ucode = '{OP_MUL,  X_C1,         R_T1,    R_P};
      7'd35: ucode = '{OP_MUL,  X_C2,         R_T2,    R_M};
      7'd36: ucode = '{OP_SUB,  R_P,          R_M,     R_S};
      7'd37: ucode = '{OP_SUB,  R_S,          X_KSI,   R_K3 + 6'd1};
      7'd38: ucode = '{OP_SUB,  R_T2,         R_KU,    R_N};
      7'd39: ucode = '{OP_DIVT, R_N,          R_N,     R_K3 + 6'd2};
      // full step with k3
      7'd40: ucode = '{OP_MUL,  R_K3,         X_DT,    R_P};
      7'd41: ucode = '{OP_ADD,  X_ANGLE,      R_P,     R_T0};
      7'd42: ucode = '{OP_MUL,  R_K3 + 6'd1,  X_DT,    R_P};
      7'd43: ucode = '{OP_ADD,  X_RATE,       R_P,     R_T1};
      7'd44: ucode = '{OP_MUL,  R_K3 + 6'd2,  X_DT,    R_P};
      7'd45: ucode = '{OP_ADD,  X_DEFL,       R_P,     R_T2};
      // fourth derivative
      7'd46: ucode = '{OP_NEG,  R_T1,         R_T1,    R_K4};
      7'd47: ucode = '{OP_MUL,  X_C1,         R_T1,    R_P};
      7'd48: ucode = '{OP_MUL,  X_C2,         R_T2,    R_M};
      7'd49: ucode = '{OP_SUB,  R_P,          R_M,     R_S};
      7'd50: ucode = '{OP_SUB,  R_S,          X_KSI,   R_K4 + 6'd1};
      7'd51: ucode = '{OP_SUB,  R_T2,         R_KU,    R_N};
      7'd52: ucode = '{OP_DIVT, R_N,          R_N,     R_K4 + 6'd2};
      // weighted sum for angle
      7'd53: ucode = '{OP_ADD,  R_K1,         R_K4,    R_S};
      7'd54: ucode = '{OP_MUL,  R_K2,         X_TWO,   R_M};
      7'd55: ucode = '{OP_ADD,  R_S,          R_M,     R_S};
      7'd56: ucode = '{OP_MUL,  R_K3,         X_TWO,   R_M};
      7'd57: ucode = '{OP_ADD,  R_S,          R_M,     R_S};
      7'd58: ucode = '{OP_MUL,  R_S,          X_DT,    R_P};
      7'd59: ucode = '{OP_DIV6, R_P,          R_P,     R_P};
      7'd60: ucode = '{OP_ADD,  X_ANGLE,      R_P,     X_ANGLE};
      // weighted sum for rate
      7'd61: ucode = '{OP_ADD,  R_K1 + 6'd1,  R_K4 + 6'd1, R_S};
      7'd62: ucode = '{OP_MUL,  R_K2 + 6'd1,  X_TWO,   R_M};
      7'd63: ucode = '{OP_ADD,  R_S,          R_M,     R_S};
      7'd64: ucode = '{OP_MUL,  R_K3 + 6'd1,  X_TWO,   R_M};
      7'd65: ucode = '{OP_ADD,  R_S,          R_M,     R_S};
      7'd66: ucode = '{OP_MUL,  R_S,          X_DT,    R_P};
      7'd67: ucode = '{OP_DIV6, R_P,          R_P,     R_P};
      7'd68: ucode = '{OP_ADD,  X_RATE,       R_P,     X_RATE};
      // weighted sum for deflection
      7'd69: ucode = '{OP_ADD,  R_K1 + 6'd2,  R_K4 + 6'd2, R_S};
      7'd70: ucode = '{OP_MUL,  R_K2 + 6'd2,  X_TWO,   R_M};
      7'd71: ucode = '{OP_ADD,  R_S,          R_M,     R_S};
      7'd72: ucode = '{OP_MUL,  R_K3 + 6'd2,  X_TWO,   R_M};
      7'd73: ucode = '{OP_ADD,  R_S,          R_M,     R_S};
      7'd74: ucode = '{OP_MUL,  R_S,          X_DT,    R_P};
      7'd75: ucode = '{OP_DIV6, R_P,          R_P,     R_P};
      7'd76: ucode = '{OP_ADD,  X_DEFL,       R_P,     X_DEFL};
      default: ucode = '{OP_ADD, R_T0,        R_T0,    R_T0};
    endcase
  endfunction

endpackage

[src/rk4_unit.sv]
module rk4_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  rk4_pkg::unit_cmd_t    cmd,
  input  logic [31:0]           opa,
  input  logic [31:0]           opb,
  input  logic [30:0]           den,
  output rk4_pkg::unit_status_t status,
  output logic [31:0]           result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MULR,
    S_DIV
  } state_t;

  state_t      state;
  logic [63:0] prod;
  logic        neg;
  logic        is_div6;
  logic [55:0] dvd;
  logic [55:0] quo;
  logic [30:0] rem;
  logic [5:0]  cnt;

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [31:0] mul_b;
  logic [32:0] add_v;
  logic [32:0] sub_v;
  logic [32:0] half_v;
  logic [63:0] rnd;
  logic [29:0] q6;
  logic [31:0] rem2;
  logic        ge;
  logic [31:0] rem_diff;
  logic [55:0] quo_next;

  // operand magnitudes and simple sums
  always_comb begin
    mag_a  = opa[31] ? (32'd0 - opa) : opa;
    mag_b  = opb[31] ? (32'd0 - opb) : opb;
    mul_b  = (cmd.op == rk4_pkg::OP_DIV6) ? rk4_pkg::RECIP_SIX : mag_b;
    add_v  = {opa[31], opa} + {opb[31], opb};
    sub_v  = {opa[31], opa} - {opb[31], opb};
    half_v = {opa[31], opa} + {32'd0, opa[31]};
  end

  // product rounding and reciprocal scaling
  always_comb begin
    rnd = prod + (64'd1 << (rk4_pkg::FRAC_BITS - 1));
    q6  = prod[63:34];
  end

  // one restoring divide step
  always_comb begin
    rem2     = {rem, dvd[55]};
    ge       = rem2 >= {1'b0, den};
    rem_diff = rem2 - {1'b0, den};
    quo_next = {quo[54:0], ge};
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      status.done <= 1'b0;
      status.sat  <= 1'b0;
    end else begin
      status.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            unique case (cmd.op)
              rk4_pkg::OP_ADD: begin
                {status.sat, result} <= rk4_pkg::sat_sum(add_v);
                status.done <= 1'b1;
              end
              rk4_pkg::OP_SUB: begin
                {status.sat, result} <= rk4_pkg::sat_sum(sub_v);
                status.done <= 1'b1;
              end
              rk4_pkg::OP_NEG: begin
                if (opa == rk4_pkg::WORD_MIN) begin
                  status.sat <= 1'b1;
                  result     <= rk4_pkg::WORD_MAX;
                end else begin
                  status.sat <= 1'b0;
                  result     <= 32'd0 - opa;
                end
                status.done <= 1'b1;
              end
              rk4_pkg::OP_HALF: begin
                status.sat  <= 1'b0;
                result      <= half_v[32:1];
                status.done <= 1'b1;
              end
              rk4_pkg::OP_MUL, rk4_pkg::OP_DIV6: begin
                prod    <= {32'd0, mag_a} * {32'd0, mul_b};
                neg     <= (cmd.op == rk4_pkg::OP_DIV6) ? opa[31] : (opa[31] ^ opb[31]);
                is_div6 <= (cmd.op == rk4_pkg::OP_DIV6);
                state   <= S_MULR;
              end
              rk4_pkg::OP_DIVT: begin
                neg <= opa[31];
                if (mag_a == 32'd0) begin
                  status.sat  <= 1'b0;
                  result      <= 32'd0;
                  status.done <= 1'b1;
                end else if (den == 31'd0) begin
                  status.sat  <= 1'b1;
                  result      <= opa[31] ? rk4_pkg::WORD_MIN : rk4_pkg::WORD_MAX;
                  status.done <= 1'b1;
                end else begin
                  dvd   <= {mag_a, 24'd0};
                  quo   <= 56'd0;
                  rem   <= 31'd0;
                  cnt   <= 6'd55;
                  state <= S_DIV;
                end
              end
              default: begin
                status.done <= 1'b1;
              end
            endcase
          end
        end
        S_MULR: begin
          if (is_div6) begin
            status.sat <= 1'b0;
            result     <= neg ? (32'd0 - {2'b00, q6}) : {2'b00, q6};
          end else begin
            {status.sat, result} <= rk4_pkg::sat_mag(neg, {16'd0, rnd[63:24]});
          end
          status.done <= 1'b1;
          state       <= S_IDLE;
        end
        S_DIV: begin
          rem <= ge ? rem_diff[30:0] : rem2[30:0];
          quo <= quo_next;
          dvd <= {dvd[54:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            {status.sat, result} <= rk4_pkg::sat_mag(neg, quo_next);
            status.done <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/rk4_linear_three_state_step.sv]
// one RK4 step per word: 77 micro-operations on one shared unit
// add, subtract, negate and halve finish from the unit's idle state, multiply and divide
// by six go through a rounding state, and each of the four divides by the time constant
// is bit-serial over 56 quotient bits; the result word is registered in the done state,
// which waits on a stalled result; the input stalls until that word has been loaded
// synchronous reset clears the state to zero and loads the register reset values
module rk4_linear_three_state_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rk4_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rk4_pkg::out_word_t out_data,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WAIT,
    S_DONE
  } state_t;

  state_t      state;
  logic [6:0]  pc;
  logic        sat_acc;

  // configuration
  logic [31:0] gain_rate;
  logic [31:0] gain_deflection;
  logic [31:0] actuator_gain;
  logic [30:0] time_constant;
  logic [30:0] step_size;
  logic [31:0] initial_angle;
  logic [31:0] initial_rate;
  logic [31:0] initial_deflection;

  // plant state and latched word
  logic [31:0] angle;
  logic [31:0] rate;
  logic [31:0] deflection;
  logic [31:0] control;
  logic [31:0] disturbance;

  // scratch store and operand registers
  logic [31:0] rf [32];
  logic [31:0] opa;
  logic [31:0] opb;

  rk4_pkg::ucode_t      uc;
  rk4_pkg::unit_cmd_t   cmd;
  rk4_pkg::unit_status_t status;
  logic [31:0]          result;
  logic [31:0]          fixed_a;
  logic [31:0]          fixed_b;

  function automatic logic [31:0] fixed_sel(input logic [5:0] code,
                                            input logic [31:0] x0,
                                            input logic [31:0] x1,
                                            input logic [31:0] x2,
                                            input logic [31:0] c1,
                                            input logic [31:0] c2,
                                            input logic [31:0] kg,
                                            input logic [31:0] dt,
                                            input logic [31:0] ksi,
                                            input logic [31:0] u);
    unique case (code)
      rk4_pkg::X_ANGLE: fixed_sel = x0;
      rk4_pkg::X_RATE:  fixed_sel = x1;
      rk4_pkg::X_DEFL:  fixed_sel = x2;
      rk4_pkg::X_C1:    fixed_sel = c1;
      rk4_pkg::X_C2:    fixed_sel = c2;
      rk4_pkg::X_KGAIN: fixed_sel = kg;
      rk4_pkg::X_DT:    fixed_sel = dt;
      rk4_pkg::X_TWO:   fixed_sel = rk4_pkg::FIX_TWO;
      rk4_pkg::X_KSI:   fixed_sel = ksi;
      rk4_pkg::X_CTRL:  fixed_sel = u;
      default:          fixed_sel = 32'd0;
    endcase
  endfunction

  // current micro-operation and fixed operands
  always_comb begin
    uc      = rk4_pkg::ucode(pc);
    fixed_a = fixed_sel(uc.a, angle, rate, deflection, gain_rate, gain_deflection,
                        actuator_gain, {1'b0, step_size}, disturbance, control);
    fixed_b = fixed_sel(uc.b, angle, rate, deflection, gain_rate, gain_deflection,
                        actuator_gain, {1'b0, step_size}, disturbance, control);
    cmd.start = (state == S_EXEC);
    cmd.op    = uc.op;
  end

  assign in_stall = (state != S_IDLE);

  rk4_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .opa    (opa),
    .opb    (opb),
    .den    (time_constant),
    .status (status),
    .result (result)
  );

  // scratch store write and registered operand read
  always_ff @(posedge clk) begin
    if (state == S_WAIT && status.done && !uc.d[5]) begin
      rf[uc.d[4:0]] <= result;
    end
    if (state == S_READ) begin
      opa <= uc.a[5] ? fixed_a : rf[uc.a[4:0]];
      opb <= uc.b[5] ? fixed_b : rf[uc.b[4:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_rate          <= 32'd0;
      gain_deflection    <= 32'd0;
      actuator_gain      <= 32'd0;
      time_constant      <= 31'd16777216;
      step_size          <= 31'd167772;
      initial_angle      <= 32'd731682;
      initial_rate       <= 32'd1463364;
      initial_deflection <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rk4_pkg::CFG_GAIN_RATE:       gain_rate          <= cfg_data;
        rk4_pkg::CFG_GAIN_DEFLECTION: gain_deflection    <= cfg_data;
        rk4_pkg::CFG_ACTUATOR_GAIN:   actuator_gain      <= cfg_data;
        rk4_pkg::CFG_TIME_CONSTANT:   time_constant      <= cfg_data[30:0];
        rk4_pkg::CFG_STEP_SIZE:       step_size          <= cfg_data[30:0];
        rk4_pkg::CFG_INITIAL_ANGLE:   initial_angle      <= cfg_data;
        rk4_pkg::CFG_INITIAL_RATE:    initial_rate       <= cfg_data;
        rk4_pkg::CFG_INITIAL_DEFL:    initial_deflection <= cfg_data;
        default: ;
      endcase
    end
  end

  // step sequencer, plant state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pc         <= 7'd0;
      sat_acc    <= 1'b0;
      angle      <= 32'd0;
      rate       <= 32'd0;
      deflection <= 32'd0;
      out_valid  <= 1'b0;
    end else begin
      // result word is loaded in the done state, dropped once taken
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            control     <= in_data.control;
            disturbance <= in_data.disturbance;
            if (in_data.restart) begin
              angle      <= initial_angle;
              rate       <= initial_rate;
              deflection <= initial_deflection;
            end
            pc      <= 7'd0;
            sat_acc <= 1'b0;
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (status.done) begin
            sat_acc <= sat_acc | status.sat;
            if (uc.d == rk4_pkg::X_ANGLE) begin
              angle <= result;
            end
            if (uc.d == rk4_pkg::X_RATE) begin
              rate <= result;
            end
            if (uc.d == rk4_pkg::X_DEFL) begin
              deflection <= result;
            end
            if (pc == rk4_pkg::PC_LAST) begin
              state <= S_DONE;
            end else begin
              pc    <= pc + 7'd1;
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data.angle_out      <= angle;
            out_data.rate_out       <= rate;
            out_data.deflection_out <= deflection;
            out_data.saturated      <= sat_acc;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
